// ===== src/suffix_array_prefix_doubling_defines.svh =====
// Assertion macros used by the top-level RTL module. They assume ports named clock and reset.
`ifndef SUFFIX_ARRAY_PREFIX_DOUBLING_DEFINES_SVH
`define SUFFIX_ARRAY_PREFIX_DOUBLING_DEFINES_SVH

`define SAPD_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`define SAPD_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SAPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sapd_pkg.sv =====
`default_nettype none
package sapd_pkg;

   localparam int MAX_LEN_DEF = 32;
   localparam int ROW_CAP = 7;
   localparam int RANK_W = 8;
   localparam logic [7:0] SENTINEL_CHAR = 8'd36;

   typedef enum logic [1:0] {
      KIND_SA  = 2'd0,
      KIND_LCP = 2'd1,
      KIND_ERR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_BLOAD,
      CMD_ROT,
      CMD_CLOAD,
      CMD_COUNT,
      CMD_COMMIT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type        cmd;
      logic [RANK_W-1:0]   rank_val;
   } cell_ctrl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BLOAD,
      S_ROT,
      S_CLOAD,
      S_COUNT,
      S_COMMIT,
      S_EMIT,
      S_EDRAIN,
      S_QRD,
      S_QCMP
   } state_type;

   // Doubling rounds needed for a cyclic string of n symbols, capped by the row count.
   function automatic logic [2:0] round_count(input logic [6:0] n);
      logic [2:0] r;
      logic [7:0] gap;
      r = 3'd0;
      gap = 8'd1;
      for (int s = 0; s < ROW_CAP - 1; s++) begin
         if (gap < {1'b0, n}) begin
            r = r + 3'd1;
            gap = gap << 1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/suffix_array_prefix_doubling.sv =====
// A final character load builds the table over a ring of cells, where n = length + 1:
// each round runs a rotation pass, a compare pass and the control states BLOAD, CLOAD
// and COMMIT; a last rotation pass fills the order memory, then one result per cycle is
// emitted and a drain state passes before the next transaction is taken.
// A prefix query walks the rank rows top down: a registered rank memory read, then a compare per row.
// Results cannot be stalled. Synchronous reset clears the length and the built flag.
`default_nettype none
`include "suffix_array_prefix_doubling_defines.svh"
module suffix_array_prefix_doubling
   import sapd_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_type,
   input  wire logic [7:0] req_character,
   input  wire logic       req_is_final_char,
   input  wire logic [5:0] req_index_a,
   input  wire logic [5:0] req_index_b,
   output logic            rsp_strobe,
   output logic [1:0]      rsp_result_kind,
   output logic [5:0]      rsp_value,
   output logic            rsp_run_end
);

   localparam int NCELL = MAX_LEN + 1;
   localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN + 1) : 1;
   localparam int N_W = $clog2(MAX_LEN + 2);
   localparam int CW = N_W + 1;
   localparam int RR_DEPTH = ROW_CAP * NCELL;
   localparam int RA_W = $clog2(RR_DEPTH);
   localparam int OA_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] len_ff, len_in, len_eff;
   logic built_ff, built_in;
   logic [N_W-1:0] n_ff, n_in;
   logic [2:0] rounds_ff, rounds_in, k_ff, k_in, qk_ff, qk_in;
   logic [CW-1:0] t_ff, t_in, gap_ff, gap_in, qgap_ff, qgap_in;
   logic [RA_W-1:0] base_ff, base_in, top_base_ff, top_base_in, qbase_ff, qbase_in;
   logic [IDX_W-1:0] e_ff, e_in;
   logic [N_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [5:0] qans_ff, qans_in, ans_next;
   logic [CW-1:0] sum_a, sum_b, diff;
   logic rsp_vld_ff, rsp_vld_in, emit_vld_ff, emit_vld_in, emit_last_ff, emit_last_in;
   kind_type rsp_kind_ff, rsp_kind_in;
   logic [5:0] rsp_val_ff, rsp_val_in;

   cell_ctrl_type ctrl;
   logic [RANK_W-1:0] b_out [NCELL];
   logic [RANK_W-1:0] b_nb [NCELL];
   logic [2*RANK_W-1:0] circ_out [NCELL];
   logic [2*RANK_W-1:0] circ_nb [NCELL];

   logic rr_we, or_we;
   logic [RA_W-1:0] rr_wa, rd_a_addr, rd_b_addr;
   logic [RANK_W-1:0] rd_a, rd_b;
   logic [OA_W-1:0] or_wa, or_ra;
   logic [5:0] or_wd, or_rd;

   // Ring of cells; the live ring closes at cell n-1.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      if (i < MAX_LEN) begin : g_mid
         assign b_nb[i] = (N_W'(i + 1) == n_ff) ? b_out[0] : b_out[i+1];
         assign circ_nb[i] = (N_W'(i + 1) == n_ff) ? circ_out[0] : circ_out[i+1];
      end else begin : g_last
         assign b_nb[i] = b_out[0];
         assign circ_nb[i] = circ_out[0];
      end
      sapd_cell #(.IDX_W(IDX_W), .IDX(i)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .wr_idx   (len_eff),
         .b_nb     (b_nb[i]),
         .circ_nb  (circ_nb[i]),
         .b_out    (b_out[i]),
         .circ_out (circ_out[i])
      );
   end

   sapd_ram #(.WIDTH(RANK_W), .DEPTH(RR_DEPTH)) u_rank_a (
      .clock(clock), .wr_en(rr_we), .wr_addr(rr_wa), .wr_data(b_out[0]),
      .rd_addr(rd_a_addr), .rd_data(rd_a)
   );
   sapd_ram #(.WIDTH(RANK_W), .DEPTH(RR_DEPTH)) u_rank_b (
      .clock(clock), .wr_en(rr_we), .wr_addr(rr_wa), .wr_data(b_out[0]),
      .rd_addr(rd_b_addr), .rd_data(rd_b)
   );
   sapd_ram #(.WIDTH(6), .DEPTH(MAX_LEN)) u_order (
      .clock(clock), .wr_en(or_we), .wr_addr(or_wa), .wr_data(or_wd),
      .rd_addr(or_ra), .rd_data(or_rd)
   );

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      built_in = built_ff;
      n_in = n_ff;
      rounds_in = rounds_ff;
      k_in = k_ff;
      qk_in = qk_ff;
      t_in = t_ff;
      gap_in = gap_ff;
      qgap_in = qgap_ff;
      base_in = base_ff;
      top_base_in = top_base_ff;
      qbase_in = qbase_ff;
      e_in = e_ff;
      qa_in = qa_ff;
      qb_in = qb_ff;
      qans_in = qans_ff;
      rsp_vld_in = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_val_in = rsp_val_ff;
      emit_vld_in = 1'b0;
      emit_last_in = 1'b0;
      ctrl.cmd = CMD_IDLE;
      ctrl.rank_val = req_character - SENTINEL_CHAR;
      len_eff = built_ff ? '0 : len_ff;
      rr_we = 1'b0;
      rr_wa = base_ff + RA_W'(t_ff);
      or_we = 1'b0;
      or_wa = OA_W'(b_out[0] - 8'd1);
      or_wd = 6'(t_ff);
      or_ra = OA_W'(e_ff);
      rd_a_addr = qbase_ff + RA_W'(qa_ff);
      rd_b_addr = qbase_ff + RA_W'(qb_ff);
      diff = CW'(n_ff) - CW'(req_index_a);
      ans_next = qans_ff;
      sum_a = CW'(qa_ff);
      sum_b = CW'(qb_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type) begin
                  if (!built_ff || 7'(req_index_a) > 7'(len_ff)
                        || 7'(req_index_b) > 7'(len_ff)) begin
                     rsp_vld_in = 1'b1;
                     rsp_kind_in = KIND_ERR;
                     rsp_val_in = '0;
                  end else if (req_index_a == req_index_b) begin
                     rsp_vld_in = 1'b1;
                     rsp_kind_in = KIND_LCP;
                     rsp_val_in = (diff > CW'(63)) ? 6'd63 : 6'(diff);
                  end else begin
                     qa_in = N_W'(req_index_a);
                     qb_in = N_W'(req_index_b);
                     qans_in = '0;
                     qk_in = rounds_ff - 3'd1;
                     qgap_in = CW'(1) << (rounds_ff - 3'd1);
                     qbase_in = top_base_ff - RA_W'(NCELL);
                     state_in = S_QRD;
                  end
               end else begin
                  built_in = 1'b0;
                  if (req_character <= SENTINEL_CHAR || 7'(len_eff) >= 7'(MAX_LEN)) begin
                     len_in = '0;
                     rsp_vld_in = 1'b1;
                     rsp_kind_in = KIND_ERR;
                     rsp_val_in = '0;
                  end else begin
                     ctrl.cmd = CMD_LOAD;
                     len_in = len_eff + 1'b1;
                     if (req_is_final_char) begin
                        n_in = N_W'(len_eff) + N_W'(2);
                        rounds_in = round_count(7'(len_eff) + 7'd2);
                        k_in = '0;
                        gap_in = CW'(1);
                        base_in = '0;
                        state_in = S_BLOAD;
                     end
                  end
               end
            end
         end
         S_BLOAD: begin
            ctrl.cmd = CMD_BLOAD;
            t_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            // Cell 0 sees position t on rotation step t, so the row streams out in order.
            ctrl.cmd = CMD_ROT;
            t_in = t_ff + 1'b1;
            if (t_ff < CW'(n_ff)) begin
               rr_we = 1'b1;
               if (k_ff == rounds_ff && b_out[0] != '0) begin
                  or_we = 1'b1;
               end
            end
            if (k_ff == rounds_ff) begin
               if (t_ff == CW'(n_ff) - 1'b1) begin
                  top_base_in = base_ff;
                  e_in = '0;
                  state_in = S_EMIT;
               end
            end else if (t_ff == CW'(n_ff) + gap_ff - 1'b1) begin
               state_in = S_CLOAD;
            end
         end
         S_CLOAD: begin
            ctrl.cmd = CMD_CLOAD;
            t_in = '0;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            ctrl.cmd = CMD_COUNT;
            t_in = t_ff + 1'b1;
            if (t_ff == CW'(n_ff) - 1'b1) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            ctrl.cmd = CMD_COMMIT;
            k_in = k_ff + 3'd1;
            gap_in = gap_ff << 1;
            base_in = base_ff + RA_W'(NCELL);
            state_in = S_BLOAD;
         end
         S_EMIT: begin
            emit_vld_in = 1'b1;
            emit_last_in = (e_ff == len_ff - 1'b1);
            if (e_ff == len_ff - 1'b1) begin
               built_in = 1'b1;
               state_in = S_EDRAIN;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         S_EDRAIN: state_in = S_IDLE;
         S_QRD: state_in = S_QCMP;
         S_QCMP: begin
            if (rd_a == rd_b) begin
               ans_next = 6'(7'(qans_ff) + 7'(qgap_ff));
               sum_a = CW'(qa_ff) + qgap_ff;
               sum_b = CW'(qb_ff) + qgap_ff;
               if (sum_a >= CW'(n_ff)) sum_a = sum_a - CW'(n_ff);
               if (sum_b >= CW'(n_ff)) sum_b = sum_b - CW'(n_ff);
            end
            qans_in = ans_next;
            qa_in = N_W'(sum_a);
            qb_in = N_W'(sum_b);
            if (qk_ff == 3'd0) begin
               rsp_vld_in = 1'b1;
               rsp_kind_in = KIND_LCP;
               rsp_val_in = ans_next;
               state_in = S_IDLE;
            end else begin
               qk_in = qk_ff - 3'd1;
               qgap_in = qgap_ff >> 1;
               qbase_in = qbase_ff - RA_W'(NCELL);
               state_in = S_QRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         built_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         emit_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         built_ff <= built_in;
         rsp_vld_ff <= rsp_vld_in;
         emit_vld_ff <= emit_vld_in;
      end
      n_ff <= n_in;
      rounds_ff <= rounds_in;
      k_ff <= k_in;
      qk_ff <= qk_in;
      t_ff <= t_in;
      gap_ff <= gap_in;
      qgap_ff <= qgap_in;
      base_ff <= base_in;
      top_base_ff <= top_base_in;
      qbase_ff <= qbase_in;
      e_ff <= e_in;
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      qans_ff <= qans_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_val_ff <= rsp_val_in;
      emit_last_ff <= emit_last_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_vld_ff | emit_vld_ff;
   assign rsp_result_kind = emit_vld_ff ? KIND_SA : rsp_kind_ff;
   assign rsp_value = emit_vld_ff ? or_rd : rsp_val_ff;
   assign rsp_run_end = emit_vld_ff ? emit_last_ff : 1'b1;

   `SAPD_ASSERT_NEVER(a_single_result, rsp_vld_ff && emit_vld_ff, "two results in one cycle")
   `SAPD_ASSERT_NEXT(a_query_progress, start && !busy && req_type, rsp_strobe || busy,
      "query transaction neither answered nor in progress")
   `SAPD_ASSERT_IMPL(a_query_built, state_ff == S_QRD || state_ff == S_QCMP, built_ff,
      "rank walk without a built table")

endmodule
`default_nettype wire

// ===== src/sapd_ram.sv =====
`default_nettype none
module sapd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/sapd_cell.sv =====
`default_nettype none
module sapd_cell
   import sapd_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int IDX = 0
) (
   input  wire logic                  clock,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic [IDX_W-1:0]      wr_idx,
   input  wire logic [RANK_W-1:0]     b_nb,
   input  wire logic [2*RANK_W-1:0]   circ_nb,
   output logic      [RANK_W-1:0]     b_out,
   output logic      [2*RANK_W-1:0]   circ_out
);

   localparam logic [IDX_W:0] ME = (IDX_W + 1)'(IDX);

   logic [RANK_W-1:0]   own_ff, own_in;
   logic [RANK_W-1:0]   b_ff, b_in;
   logic [2*RANK_W-1:0] circ_ff, circ_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      own_in = own_ff;
      b_in = b_ff;
      circ_in = circ_ff;
      cnt_in = cnt_ff;
      case (ctrl.cmd)
         CMD_LOAD: begin
            // The cell after the newest character holds the sentinel until overwritten.
            if ({1'b0, wr_idx} == ME) begin
               own_in = ctrl.rank_val;
            end else if ({1'b0, wr_idx} + 1'b1 == ME) begin
               own_in = '0;
            end
         end
         CMD_BLOAD: b_in = own_ff;
         CMD_ROT: b_in = b_nb;
         CMD_CLOAD: begin
            circ_in = {own_ff, b_ff};
            cnt_in = '0;
         end
         CMD_COUNT: begin
            if (circ_ff < {own_ff, b_ff}) begin
               cnt_in = cnt_ff + 1'b1;
            end
            circ_in = circ_nb;
         end
         CMD_COMMIT: own_in = RANK_W'(cnt_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      own_ff <= own_in;
      b_ff <= b_in;
      circ_ff <= circ_in;
      cnt_ff <= cnt_in;
   end

   assign b_out = b_ff;
   assign circ_out = circ_ff;

endmodule
`default_nettype wire

// ===== sim/sapd_checker.sv =====
`timescale 1ns / 1ps
module sapd_checker
   import sapd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  wire logic       req_type,
   input  wire logic [7:0] req_character,
   input  wire logic       req_is_final_char,
   input  wire logic [5:0] req_index_a,
   input  wire logic [5:0] req_index_b,
   input  wire logic       rsp_strobe,
   input  wire logic [1:0] rsp_result_kind,
   input  wire logic [5:0] rsp_value,
   input  wire logic       rsp_run_end,
   output int              fail_count,
   output int              pending,
   output int              sa_seen,
   output int              lcp_seen,
   output int              err_seen
);

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] value;
      logic       run_end;
   } answer_type;

   answer_type answers_due[$];

   logic [7:0] text_copy [0:32];
   int         text_len;
   logic [7:0] ranks [0:6][0:32];
   int         suffix_order [0:31];
   bit         built;

   function automatic int rounds_for(int n);
      int r;
      int gap;
      r = 0;
      gap = 1;
      while (gap < n && r + 1 < 7) begin
         r++;
         gap = gap << 1;
      end
      return r;
   endfunction

   task automatic rebuild_ranks();
      int n;
      int rounds;
      int gap;
      int i;
      int j;
      int v;
      int cur;
      int prev;
      int pairs [0:32];
      n = text_len + 1;
      rounds = rounds_for(n);
      gap = 1;
      for (i = 0; i < text_len; i++) ranks[0][i] = text_copy[i] - 8'd36;
      ranks[0][text_len] = '0;
      for (int k = 1; k <= rounds; k++) begin
         for (i = 0; i < n; i++)
            pairs[i] = (int'(ranks[k-1][i]) << 14) | (int'(ranks[k-1][(i + gap) % n]) << 6) | i;
         for (i = 1; i < n; i++) begin
            v = pairs[i];
            j = i;
            while (j > 0 && pairs[j-1] > v) begin
               pairs[j] = pairs[j-1];
               j--;
            end
            pairs[j] = v;
         end
         ranks[k][pairs[0] & 63] = '0;
         for (i = 1; i < n; i++) begin
            cur = pairs[i] & 63;
            prev = pairs[i-1] & 63;
            if ((pairs[i] >> 6) == (pairs[i-1] >> 6)) ranks[k][cur] = ranks[k][prev];
            else ranks[k][cur] = 8'(i);
         end
         gap = gap << 1;
      end
      for (i = 0; i < text_len; i++) begin
         v = int'(ranks[rounds][i]);
         if (v >= 1 && v <= text_len) suffix_order[v-1] = i;
      end
      built = 1;
   endtask

   function automatic int prefix_length(int a, int b);
      int n;
      int ans;
      int gap;
      n = text_len + 1;
      ans = 0;
      if (a == b) return (n - a) > 63 ? 63 : n - a;
      for (int k = rounds_for(n) - 1; k >= 0; k--) begin
         gap = 1 << k;
         if (ranks[k][a] == ranks[k][b]) begin
            ans += gap;
            a = (a + gap) % n;
            b = (b + gap) % n;
         end
      end
      return ans > 63 ? 63 : ans;
   endfunction

   task automatic predict_transaction();
      answer_type e;
      if (req_type) begin
         if (!built || int'(req_index_a) > text_len || int'(req_index_b) > text_len)
            e = '{KIND_ERR, 6'd0, 1'b1};
         else
            e = '{KIND_LCP, 6'(prefix_length(int'(req_index_a), int'(req_index_b))), 1'b1};
         answers_due.push_back(e);
         return;
      end
      if (built) begin
         built = 0;
         text_len = 0;
      end
      if (req_character <= 8'd36 || text_len >= 32) begin
         text_len = 0;
         answers_due.push_back('{KIND_ERR, 6'd0, 1'b1});
         return;
      end
      text_copy[text_len] = req_character;
      text_len++;
      if (!req_is_final_char) return;
      rebuild_ranks();
      for (int i = 0; i < text_len; i++)
         answers_due.push_back('{KIND_SA, 6'(suffix_order[i]), 1'(i + 1 == text_len)});
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         text_len = 0;
         built = 0;
         answers_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result kind=%0d value=%0d end=%0d",
                     rsp_result_kind, rsp_value, rsp_run_end);
            end else begin
               want = answers_due.pop_front();
               if (want.kind == KIND_SA) sa_seen++;
               else if (want.kind == KIND_LCP) lcp_seen++;
               else err_seen++;
               if (want.kind !== rsp_result_kind || want.value !== rsp_value ||
                   want.run_end !== rsp_run_end) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected kind=%0d value=%0d end=%0d, got %0d %0d %0d",
                        want.kind, want.value, want.run_end,
                        rsp_result_kind, rsp_value, rsp_run_end);
               end
            end
         end
         if (start && !busy) predict_transaction();
      end
      pending = answers_due.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      sa_seen = 0;
      lcp_seen = 0;
      err_seen = 0;
   end

endmodule

// ===== sim/tb_suffix_array_prefix_doubling.sv =====
`timescale 1ns / 1ps
module tb_suffix_array_prefix_doubling;
   import sapd_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   logic       req_type = 0;
   logic [7:0] req_character = 0;
   logic       req_is_final_char = 0;
   logic [5:0] req_index_a = 0;
   logic [5:0] req_index_b = 0;
   logic       rsp_strobe;
   logic [1:0] rsp_result_kind;
   logic [5:0] rsp_value;
   logic       rsp_run_end;
   int         fail_count;
   int         pending;
   int         sa_seen;
   int         lcp_seen;
   int         err_seen;
   int         idle_pct = 0;
   int         sent = 0;
   int         quiet_cycles = 0;
   int         cur_len = 0;

   localparam int WATCHDOG = 20000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   suffix_array_prefix_doubling dut (.*);

   sapd_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("[suffix_array_prefix_doubling] ERROR");
         $finish;
      end
   end

   // Presents one transaction and holds it until accepted, with random idle gaps.
   // A negative cur_len -(L + 1) marks a built string of length L.
   task automatic issue(input logic typ, input logic [7:0] ch, input logic fin,
                        input logic [5:0] ia, input logic [5:0] ib);
      int base_len;
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_type <= typ;
      req_character <= ch;
      req_is_final_char <= fin;
      req_index_a <= ia;
      req_index_b <= ib;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      if (typ) return;
      base_len = (cur_len < 0) ? 0 : cur_len;
      if (ch <= 8'd36 || base_len >= 32) cur_len = 0;
      else if (fin) cur_len = -(base_len + 2);
      else cur_len = base_len + 1;
   endtask

   task automatic load_string(input int len, input int lo, input int hi);
      for (int i = 0; i < len; i++)
         issue(0, 8'($urandom_range(hi, lo)), i == len - 1, 6'($urandom), 6'($urandom));
   endtask

   task automatic query_pair();
      int top;
      top = (cur_len < 0) ? -cur_len - 1 : 32;
      if ($urandom_range(9) == 0)
         issue(1, 8'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
      else
         issue(1, 8'($urandom), 1'($urandom), 6'($urandom_range(top)),
               6'($urandom_range(top)));
   endtask

   initial begin
      int choice;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: query before any build, bad characters, overflow, extremes.
      issue(1, 8'd0, 0, 6'd0, 6'd0);
      issue(0, 8'd37, 0, 6'd0, 6'd0);
      issue(0, 8'd36, 0, 6'd0, 6'd0);
      issue(0, 8'd0, 1, 6'd0, 6'd0);
      issue(0, 8'd255, 1, 6'd63, 6'd63);
      issue(1, 8'd255, 1, 6'd0, 6'd1);
      issue(1, 8'd0, 0, 6'd1, 6'd1);
      issue(1, 8'd0, 0, 6'd2, 6'd0);
      issue(1, 8'd0, 0, 6'd63, 6'd63);
      for (int i = 0; i < 33; i++) issue(0, 8'd97, 0, 6'd0, 6'd0);
      load_string(32, 97, 97);
      issue(1, 8'd0, 0, 6'd0, 6'd0);
      issue(1, 8'd0, 0, 6'd1, 6'd2);
      issue(1, 8'd0, 0, 6'd32, 6'd0);
      issue(1, 8'd0, 0, 6'd33, 6'd0);
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 69 : (phase == 3) ? 14 : 0;
         while (sent < (phase + 1) * 120) begin
            choice = $urandom_range(9);
            if (choice < 4) begin
               if ($urandom_range(7) == 0) load_string($urandom_range(32, 20), 37, 255);
               else load_string($urandom_range(6, 1), 97, $urandom_range(99, 98));
            end else if (choice < 9) begin
               query_pair();
            end else begin
               issue(0, 8'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
            end
         end
      end
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("sent %0d transactions: %0d suffix entries, %0d prefix answers, %0d errors",
         sent, sa_seen, lcp_seen, err_seen);
      if (fail_count == 0 && pending == 0) $display("[suffix_array_prefix_doubling] OK");
      else $display("[suffix_array_prefix_doubling] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/sapd_pkg.sv
src/sapd_ram.sv
src/sapd_cell.sv
src/suffix_array_prefix_doubling.sv
sim/sapd_checker.sv
sim/tb_suffix_array_prefix_doubling.sv
